// ----- hw/rtl/block_bitmap_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Field widths, operation and status codes, register map and defaults.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ID_W  = 12;
  localparam int CNT_W = 13;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam int MAX_BLOCKS_DEF  = 4096;
  localparam int BITMAP_WORD_DEF = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [ID_W-1:0]  DATA_START_RST  = 12'd1;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_IGNORED   = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]  data_start;
    logic [CNT_W-1:0] block_count;
  } cfg_t;

endpackage

// ----- hw/rtl/bba_ifs.sv -----
// ----------------------------------------------------------------------------
// Block bitmap allocator channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [ID_W-1:0] blk_id;

  modport source (output valid, output opcode, output blk_id, input ready);
  modport sink   (input valid, input opcode, input blk_id, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] result_id;
  logic [ST_W-1:0] status;
  logic            is_free_flag;

  modport source (output valid, output result_id, output status, output is_free_flag,
                  input ready);
  modport sink   (input valid, input result_id, input status, input is_free_flag,
                  output ready);
endinterface

// ----- hw/rtl/block_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit disk block allocator over a used-bit map held in word memory.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (opcode, blk_id) and each one produces exactly one
// response on rsp_o (result_id, status, is_free_flag); both use valid/ready.
// The block works on one request at a time: req_i.ready is high only while the
// sequencer is idle and no response is waiting, so a stalled receiver holds
// the response register and back-pressures new requests.
// A free or query request walks one bitmap word per cycle to the word holding
// blk_id and reads it. An allocate request walks to the word of data_start the
// same way, then scans one memory word per cycle until a free bit or the block
// count is reached. The walk and the scan are paced by the single memory read
// port and the one base adder. After reset the bitmap is cleared one word per
// cycle, with requests held off. data_start (index 0) and block_count (index 1)
// are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; write them only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MaxBlocks  = MAX_BLOCKS_DEF,
  parameter int BitmapWord = BITMAP_WORD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bba_req_if.sink               req_i,
  bba_rsp_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Word count of the bitmap and the address width of its memory.
  localparam int MapDepth = (MaxBlocks + BitmapWord - 1) / BitmapWord;
  localparam int AddrW    = (MapDepth > 1) ? $clog2(MapDepth) : 1;

  cfg_t cfg_q;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [BitmapWord-1:0] ram_wdata;
  logic                  ram_re;
  logic [AddrW-1:0]      ram_raddr;
  logic [BitmapWord-1:0] ram_rdata;

  // Handshake and response terms used by the checks below.
  logic req_fire;
  logic rsp_none_free;
  logic rsp_flag;
  logic rsp_clean;

  // Configuration registers. A data_start of zero is handled as one by the
  // sequencer, so the low ID_W bits of the write data are stored unchanged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_start  <= DATA_START_RST;
      cfg_q.block_count <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DATA_START:  cfg_q.data_start  <= cfg_wdata_i[ID_W-1:0];
        REG_BLOCK_COUNT: cfg_q.block_count <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bba_ctrl #(
    .MaxBlocks  (MaxBlocks),
    .BitmapWord (BitmapWord),
    .MapDepth   (MapDepth),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bba_map_ram #(
    .Depth (MapDepth),
    .Width (BitmapWord),
    .AddrW (AddrW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_none_free = rsp_o.valid && (rsp_o.status == ST_NONE_FREE);
  assign rsp_flag      = rsp_o.valid && rsp_o.is_free_flag;
  assign rsp_clean     = (rsp_o.status == ST_DONE) && (rsp_o.result_id == '0);

  // The block never takes a request while a response is still pending.
  `BBA_ASSERT_NOW(a_ready_excl_valid, req_i.ready, !rsp_o.valid, "ready with response pending")
  // An accepted request always leaves req_i.ready low in the cycle after the accept.
  `BBA_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_i.ready, "ready after accept")
  // A failed allocation reports block zero.
  `BBA_ASSERT_NOW(a_none_free_zero, rsp_none_free, rsp_o.result_id == '0, "none-free with id")
  // Only a successful query raises the free flag, and it carries no block number.
  `BBA_ASSERT_NOW(a_flag_clean, rsp_flag, rsp_clean, "free flag with other fields set")

endmodule

// ----- hw/rtl/bba_map_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int Depth = 64,
  parameter int Width = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bba_word_scan.sv -----
// ----------------------------------------------------------------------------
// Bitmap word scanner
// Finds the lowest clear bit of one word inside a window of bit positions.
// ----------------------------------------------------------------------------
module bba_word_scan #(
  parameter int Width = 64,
  parameter int OffW  = 6
) (
  input  logic [Width-1:0] word_i,
  input  logic [OffW-1:0]  lo_i,
  input  logic [OffW:0]    hi_i,
  output logic             found_o,
  output logic [OffW-1:0]  pos_o
);

  logic [Width-1:0] cand;

  // A bit is a candidate when it is clear and lo <= position < hi.
  always_comb begin
    for (int j = 0; j < Width; j++) begin
      cand[j] = !word_i[j] && ((OffW+1)'(j) >= {1'b0, lo_i}) && ((OffW+1)'(j) < hi_i);
    end
  end

  always_comb begin
    pos_o = '0;
    for (int j = Width - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos_o = OffW'(j);
      end
    end
  end

  assign found_o = |cand;

endmodule

// ----- hw/rtl/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Block bitmap allocator sequencer
// Clears the bitmap after reset, walks to the target word and scans or updates it.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int MaxBlocks  = MAX_BLOCKS_DEF,
  parameter int BitmapWord = BITMAP_WORD_DEF,
  parameter int MapDepth   = (MaxBlocks + BitmapWord - 1) / BitmapWord,
  parameter int AddrW      = (MapDepth > 1) ? $clog2(MapDepth) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  bba_req_if.sink               req_i,
  bba_rsp_if.source             rsp_o,
  output logic                  ram_we_o,
  output logic [AddrW-1:0]      ram_waddr_o,
  output logic [BitmapWord-1:0] ram_wdata_o,
  output logic                  ram_re_o,
  output logic [AddrW-1:0]      ram_raddr_o,
  input  logic [BitmapWord-1:0] ram_rdata_i
);

  localparam int OffW = $clog2(BitmapWord);
  // Block numbers carry one spare bit so that base plus one word never wraps.
  localparam int NumW = ((CNT_W > $clog2(MaxBlocks + 1)) ? CNT_W : $clog2(MaxBlocks + 1)) + 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SEEK = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] word_q, word_d;
  logic [NumW-1:0] base_q, base_d;
  logic [NumW-1:0] target_q, target_d;
  logic [NumW-1:0] lim_q, lim_d;
  logic [NumW-1:0] first_q, first_d;
  op_e             op_q, op_d;
  logic            out_valid_q, out_valid_d;
  logic [ID_W-1:0] res_id_q, res_id_d;
  status_e         status_q, status_d;
  logic            flag_q, flag_d;

  logic [NumW-1:0]       next_base;
  logic [NumW-1:0]       off_full;
  logic [OffW-1:0]       off;
  logic [NumW-1:0]       room;
  logic [OffW:0]         hi;
  logic                  found;
  logic [OffW-1:0]       pos;
  logic [BitmapWord-1:0] off_mask;
  logic [BitmapWord-1:0] pos_mask;
  logic [NumW-1:0]       bc_ext;
  logic [NumW-1:0]       max_ext;

  // The one shared adder steps the word base; the other terms are offsets from the base and masks.
  assign next_base = base_q + NumW'(BitmapWord);
  assign off_full  = target_q - base_q;
  assign off       = off_full[OffW-1:0];
  assign room      = lim_q - base_q;
  assign hi        = (room >= NumW'(BitmapWord)) ? (OffW+1)'(BitmapWord) : room[OffW:0];
  assign off_mask  = BitmapWord'(1) << off;
  assign pos_mask  = BitmapWord'(1) << pos;
  assign bc_ext    = NumW'(cfg_i.block_count);
  assign max_ext   = NumW'(MaxBlocks);

  bba_word_scan #(
    .Width (BitmapWord),
    .OffW  (OffW)
  ) u_scan (
    .word_i  (ram_rdata_i),
    .lo_i    (off),
    .hi_i    (hi),
    .found_o (found),
    .pos_o   (pos)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    word_d      = word_q;
    base_d      = base_q;
    target_d    = target_q;
    lim_d       = lim_q;
    first_d     = first_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    res_id_d    = res_id_q;
    status_d    = status_q;
    flag_d      = flag_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = word_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = word_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        if (clr_q == AddrW'(MapDepth - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          op_d     = op_e'(req_i.opcode);
          first_d  = (cfg_i.data_start == '0) ? NumW'(1) : NumW'(cfg_i.data_start);
          lim_d    = (bc_ext < max_ext) ? bc_ext : max_ext;
          word_d   = '0;
          base_d   = '0;
          res_id_d = '0;
          status_d = ST_DONE;
          flag_d   = 1'b0;
          case (req_i.opcode)
            OP_ALLOC: begin
              target_d = (cfg_i.data_start == '0) ? NumW'(1) : NumW'(cfg_i.data_start);
              state_d  = S_SEEK;
            end
            OP_FREE, OP_QUERY: begin
              target_d = NumW'(req_i.blk_id);
              state_d  = S_SEEK;
            end
            default: begin
              // Unused opcode: answer at once with all fields zero.
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_SEEK: begin
        if ((op_q == OP_ALLOC) && (target_q >= lim_q)) begin
          status_d    = ST_NONE_FREE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if ((op_q != OP_ALLOC) && (target_q >= max_ext)) begin
          // Ids beyond storage read as used.
          status_d    = (op_q == OP_FREE) ? ST_IGNORED : ST_DONE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (target_q >= next_base) begin
          word_d = word_q + AddrW'(1);
          base_d = next_base;
        end else begin
          ram_re_o = 1'b1;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        case (op_q)
          OP_ALLOC: begin
            if (found) begin
              ram_we_o    = 1'b1;
              ram_wdata_o = ram_rdata_i | pos_mask;
              res_id_d    = ID_W'(base_q + NumW'(pos));
              status_d    = ST_DONE;
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end else if (next_base < lim_q) begin
              ram_re_o    = 1'b1;
              ram_raddr_o = word_q + AddrW'(1);
              word_d      = word_q + AddrW'(1);
              base_d      = next_base;
              target_d    = next_base;
            end else begin
              status_d    = ST_NONE_FREE;
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          OP_FREE: begin
            if ((target_q >= first_q) && ((ram_rdata_i & off_mask) != '0)) begin
              ram_we_o    = 1'b1;
              ram_wdata_o = ram_rdata_i & ~off_mask;
              status_d    = ST_DONE;
            end else begin
              status_d    = ST_IGNORED;
            end
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
          default: begin
            flag_d      = ((ram_rdata_i & off_mask) == '0);
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    base_q   <= base_d;
    target_q <= target_d;
    lim_q    <= lim_d;
    first_q  <= first_d;
    op_q     <= op_d;
    res_id_q <= res_id_d;
    status_q <= status_d;
    flag_q   <= flag_d;
  end

  assign req_i.ready        = (state_q == S_IDLE) && !out_valid_q;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_id    = res_id_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.is_free_flag = flag_q;

endmodule

// ----- dv/block_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives allocate, free, query and unused-opcode requests through the valid/ready
// channels and checks every response against a bit-accurate bitmap predictor.
// ----------------------------------------------------------------------------
// The testbench keeps its own copy of the used-block map and of the two
// configuration registers. Each request is predicted at the edge where it is
// accepted, because the block serves one request at a time in arrival order.
// The expected response is queued, and a monitor compares every response it
// sees against the oldest queued one, field by field.
//
// The stimulus starts with a directed set of corner requests. It then runs
// phases of random traffic, each under its own register setting. Most free
// and query ids fall in a narrow window around the allocatable range, so the
// map fills up, refuses allocations, and gets blocks back through frees. The
// other ids are taken from the whole id range, so every id bit is exercised.
//
// The registers are rewritten only when the block is idle. That means no
// response is still expected and the request channel reports ready again.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_tb;
  import bba_pkg::*;

  localparam int MAP_WORDS = MAX_BLOCKS_DEF / BITMAP_WORD_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int IDLE_HOLD_MAX = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_PERCENT = 24;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [ST_W-1:0] status;
    logic            is_free_flag;
  } alloc_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bba_req_if req ();
  bba_rsp_if rsp ();

  block_bitmap_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #4 clk_i = ~clk_i;

  // The predictor's own view of the block: the used map and the registers.
  logic [BITMAP_WORD_DEF-1:0] used_words [MAP_WORDS];
  logic [ID_W-1:0]  cur_start;
  logic [CNT_W-1:0] cur_count;

  alloc_rsp_t expected_rsp [$];
  bit         idle_en;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned n_requests, n_granted, n_refused, n_ignored, n_queries;

  function automatic bit block_used(input int unsigned id);
    if (id >= MAX_BLOCKS_DEF) return 1'b1;
    return used_words[id / BITMAP_WORD_DEF][id % BITMAP_WORD_DEF];
  endfunction

  // Computes the response for one request and updates the used map with it.
  function automatic alloc_rsp_t predict_allocation(input logic [OP_W-1:0] op,
                                                    input logic [ID_W-1:0] id);
    alloc_rsp_t  r;
    int unsigned first_id, limit;
    r = '0;
    r.status = ST_DONE;
    // A start of zero still protects block 0, since id 0 means no block.
    first_id = (cur_start == '0) ? 1 : int'(cur_start);
    limit = (cur_count < MAX_BLOCKS_DEF) ? int'(cur_count) : MAX_BLOCKS_DEF;
    n_requests++;
    case (op)
      OP_ALLOC: begin
        r.status = ST_NONE_FREE;
        for (int unsigned b = first_id; b < limit; b++) begin
          if (!block_used(b)) begin
            used_words[b / BITMAP_WORD_DEF][b % BITMAP_WORD_DEF] = 1'b1;
            r.result_id = b[ID_W-1:0];
            r.status = ST_DONE;
            break;
          end
        end
        if (r.status == ST_DONE) n_granted++;
        else n_refused++;
      end
      OP_FREE: begin
        // Reserved blocks and blocks that are already free stay as they are.
        if (id >= first_id && block_used(id)) begin
          used_words[id / BITMAP_WORD_DEF][id % BITMAP_WORD_DEF] = 1'b0;
        end else begin
          r.status = ST_IGNORED;
          n_ignored++;
        end
      end
      OP_QUERY: begin
        r.is_free_flag = !block_used(id);
        n_queries++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // The response side. It checks each accepted response and then draws the next
  // ready value. The values read here are those from before this edge.
  always @(posedge clk_i) begin
    alloc_rsp_t exp_rsp;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("response with no request outstanding: result_id %0d status %0d",
               rsp.result_id, rsp.status);
        mismatches++;
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (rsp.result_id !== exp_rsp.result_id) begin
          $error("result_id: expected %0d, actual %0d", exp_rsp.result_id, rsp.result_id);
          mismatches++;
        end
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
          mismatches++;
        end
        if (rsp.is_free_flag !== exp_rsp.is_free_flag) begin
          $error("is_free_flag: expected %0d, actual %0d",
                 exp_rsp.is_free_flag, rsp.is_free_flag);
          mismatches++;
        end
      end
    end
    rsp.ready <= idle_en ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
  end

  // The watchdog ends the run when no request and no response moves for too long.
  always @(posedge clk_i) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no channel activity for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one request, holds it until it is accepted, and then queues the
  // predicted response. Valid stays high into the next request unless a gap
  // is drawn, so it never gets two assignments in one time step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int unsigned gap;
    alloc_rsp_t  pred;
    gap = 0;
    if (idle_en) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.opcode <= op;
    req.blk_id <= id;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    pred = predict_allocation(op, id);
    expected_rsp = {expected_rsp, pred};
  endtask

  // Stops sending, waits for every outstanding response, and then waits for the
  // request channel to report ready. After reset, that last wait also covers
  // the pass that clears the map.
  task automatic wait_drained();
    int unsigned hold;
    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    hold = 0;
    do begin
      @(posedge clk_i);
      hold++;
    end while (req.ready !== 1'b1 && hold < IDLE_HOLD_MAX);
  endtask

  // Writes both registers on back-to-back edges while the block is idle. The
  // data_start register keeps only its low 12 bits of the write data.
  task automatic configure(input logic [CFG_DATA_W-1:0] start_word,
                           input logic [CFG_DATA_W-1:0] count_word);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DATA_START;
    cfg_wdata <= start_word;
    @(posedge clk_i);
    cur_start = start_word[ID_W-1:0];
    cfg_idx   <= REG_BLOCK_COUNT;
    cfg_wdata <= count_word;
    @(posedge clk_i);
    cur_count = count_word;
    cfg_we    <= 1'b0;
  endtask

  // Most ids fall in the window around the allocatable range. The rest are drawn
  // from the full id range.
  function automatic logic [ID_W-1:0] pick_id(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(99) < 80) return ID_W'($urandom_range(hi, lo));
    return ID_W'($urandom_range(MAX_BLOCKS_DEF - 1));
  endfunction

  // Random traffic that favors allocation over free. The window fills up, which
  // leads to refused allocations, and frees then give blocks back.
  task automatic run_mix(input int unsigned n_req, input int unsigned id_hi);
    int unsigned lo, hi, pick;
    lo = (cur_start > 2) ? cur_start - 2 : 0;
    hi = (id_hi > MAX_BLOCKS_DEF - 1) ? MAX_BLOCKS_DEF - 1 : id_hi;
    if (hi < lo) hi = lo;
    for (int unsigned k = 0; k < n_req; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_request(OP_ALLOC, ID_W'($urandom_range(MAX_BLOCKS_DEF - 1)));
      else if (pick < 80) send_request(OP_FREE, pick_id(lo, hi));
      else if (pick < 95) send_request(OP_QUERY, pick_id(lo, hi));
      else send_request(OP_UNUSED, ID_W'($urandom_range(MAX_BLOCKS_DEF - 1)));
    end
  endtask

  // Corner cases at the reset setting and at the register extremes. These
  // include a start of zero, a count beyond the map, a count of zero, and a
  // start above the count.
  task automatic test_directed_corners();
    send_request(OP_QUERY, 12'd0);
    send_request(OP_ALLOC, 12'hFFF);
    send_request(OP_ALLOC, 12'd0);
    send_request(OP_QUERY, 12'd1);
    send_request(OP_QUERY, 12'hFFF);
    send_request(OP_FREE, 12'd0);          // Reserved block, so it is ignored.
    send_request(OP_FREE, 12'd3);          // Already free, so it is ignored.
    send_request(OP_FREE, 12'd1);
    send_request(OP_ALLOC, 12'h555);       // Gets block 1 back.
    send_request(OP_UNUSED, 12'hFFF);
    send_request(OP_QUERY, 12'hAAA);
    send_request(OP_QUERY, 12'h555);
    // The upper write bit must be dropped, which leaves a start of 4095.
    configure(13'h1FFF, 13'd4096);
    send_request(OP_ALLOC, 12'd0);
    send_request(OP_ALLOC, 12'd0);         // Only one block was allocatable.
    send_request(OP_QUERY, 12'hFFF);
    send_request(OP_FREE, 12'd2);          // Marked, but below the start.
    send_request(OP_FREE, 12'hFFF);
    send_request(OP_ALLOC, 12'd0);
    configure(13'd0, 13'h1FFF);
    send_request(OP_ALLOC, 12'd0);
    send_request(OP_FREE, 12'd0);
    send_request(OP_QUERY, 12'd0);
    configure(13'd1, 13'd0);
    send_request(OP_ALLOC, 12'd0);
    send_request(OP_FREE, 12'hFFF);        // Lies above the count, but is still freeable.
    send_request(OP_QUERY, 12'hFFF);
  endtask

  // Fills and empties small windows at several settings. One of the settings is drawn at random.
  task automatic test_fill_and_release();
    int unsigned start_rnd;
    configure(13'd10, 13'd80);
    run_mix(160, 82);
    configure(13'd0, 13'd40);
    run_mix(120, 42);
    configure(13'd4000, 13'd4096);
    run_mix(120, 4095);
    start_rnd = $urandom_range(4000, 1);
    configure(CFG_DATA_W'(start_rnd), CFG_DATA_W'(start_rnd + $urandom_range(90, 20)));
    run_mix(160, start_rnd + 100);
  endtask

  // Lowering the count keeps the marks above it. They still free and query.
  task automatic test_lowered_count();
    configure(13'd10, 13'd80);
    run_mix(30, 82);
    configure(13'd10, 13'd30);
    run_mix(100, 82);
  endtask

  // A count beyond the map size, with the back-to-back traffic of the long
  // stretch that has no idling on either side.
  task automatic test_wide_count_streaming();
    configure(13'd100, 13'd8191);
    idle_en = 1'b0;
    run_mix(160, 350);
    idle_en = 1'b1;
  endtask

  // A start above the count refuses every allocation.
  task automatic test_start_above_count();
    configure(13'd200, 13'd150);
    run_mix(60, 260);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_DATA_START;
    cfg_wdata     = '0;
    req.valid     = 1'b0;
    req.opcode    = OP_ALLOC;
    req.blk_id    = '0;
    rsp.ready     = 1'b0;
    idle_en       = 1'b1;
    mismatches    = 0;
    stall_cycles  = 0;
    n_requests    = 0;
    n_granted     = 0;
    n_refused     = 0;
    n_ignored     = 0;
    n_queries     = 0;
    cur_start     = DATA_START_RST;
    cur_count     = BLOCK_COUNT_RST;
    foreach (used_words[w]) used_words[w] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let the map-clearing pass finish before the first request goes out.
    wait_drained();
    test_directed_corners();
    test_fill_and_release();
    test_lowered_count();
    test_wide_count_streaming();
    test_start_above_count();

    // Let any stray response show up before the final verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp.size());
      mismatches++;
    end

    $display("Covered %0d requests: %0d blocks granted, %0d refused allocations,",
             n_requests, n_granted, n_refused);
    $display("%0d ignored frees and %0d queries under a range of register settings.",
             n_ignored, n_queries);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
